### rtl/rhht_pkg.sv
// Shared types and constants for the Robin Hood hash table.
`default_nettype none
package rhht_pkg;
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_GET   = 2'd1;
    localparam logic [1:0] CMD_DEL   = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [63:0] ZERO_HASH_SUBST = 64'd31;
    localparam int LOAD_NUM = 10;
    localparam int LOAD_DEN = 9;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] key_hash;
        logic [31:0] lookup_key;
        logic [31:0] in_value;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        was_present;
        logic [31:0] out_value;
        logic [7:0]  slot_index;
        logic [8:0]  entry_count;
    } t_rsp;
endpackage
`default_nettype wire

### rtl/robin_hood_hash_table.sv
// Robin Hood hash table with backward-shift deletion, one slot per step.
`default_nettype none
// Usage: drive i_req and raise start while busy is low; that beat is taken
// and busy rises on the next cycle. The block then walks the table one slot
// at a time with a single memory read port and a single distance
// subtractor. When the work is over, o_done is high for exactly
// one cycle with o_rsp valid; the receiver cannot stall, so the result is
// simply presented and dropped. busy is already low in that strobe cycle,
// so the next beat may be taken at the edge that ends it.
//
// Sequence: every slot visited takes a read-issue state and then a decide
// state that works on the registered read data. A get walks the lookup
// states only, then a dispatch state and a done state; a put that must
// insert adds a pass through the insertion walk, and a delete that hits
// adds a pass through the backward-shift walk.
//
// Reset: a synchronous active-low reset empties the table. Each slot's
// occupancy lives in a flip-flop valid bit cleared at once, so no clearing
// pass is needed; key and value stores are left undefined and are read only
// from occupied slots. The entry count is cleared too.
module robin_hood_hash_table
    import rhht_pkg::*;
#(
    parameter int CAPACITY   = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire t_req   i_req,
    output logic        o_done,
    output t_rsp        o_rsp
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] ONE = AW'(1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LREAD = 4'd1;
    localparam logic [3:0] S_LDEC  = 4'd2;
    localparam logic [3:0] S_DISP  = 4'd3;
    localparam logic [3:0] S_IREAD = 4'd4;
    localparam logic [3:0] S_IDEC  = 4'd5;
    localparam logic [3:0] S_RREAD = 4'd6;
    localparam logic [3:0] S_RDEC  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    // Storage: hash, key, value memories plus occupancy flops.
    logic [63:0]           m_hash [CAPACITY];
    logic [KEY_BITS-1:0]   m_key  [CAPACITY];
    logic [VALUE_BITS-1:0] m_data [CAPACITY];
    logic [CAPACITY-1:0]   r_valid;

    logic [3:0]            r_state;
    logic [1:0]            r_cmd;
    logic [63:0]           r_h;
    logic [KEY_BITS-1:0]   r_k;
    logic [VALUE_BITS-1:0] r_v;
    logic [AW-1:0]         r_pos;
    logic [AW:0]           r_len;
    logic [AW-1:0]         r_where;
    logic                  r_found;
    logic                  r_full;
    logic [CW-1:0]         r_count;
    logic [VALUE_BITS-1:0] r_outv;

    // Registered read data for the slot at r_pos.
    logic [63:0]           r_rh;
    logic [KEY_BITS-1:0]   r_rk;
    logic [VALUE_BITS-1:0] r_rd;
    logic                  r_rv;

    // Write port.
    logic                  w_en;
    logic [AW-1:0]         w_addr;
    logic [63:0]           w_hash;
    logic [KEY_BITS-1:0]   w_key;
    logic [VALUE_BITS-1:0] w_data;

    logic [AW-1:0] probe_off;
    logic          load_over;
    logic [63:0]   in_h;

    assign probe_off = r_pos - r_rh[AW-1:0];
    assign in_h = (i_req.key_hash == 64'd0) ? ZERO_HASH_SUBST : i_req.key_hash;
    assign load_over = (LOAD_NUM * (32'(r_count) + 32'd1)) > (LOAD_DEN * CAPACITY);
    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        r_rh <= m_hash[r_pos];
        r_rk <= m_key[r_pos];
        r_rd <= m_data[r_pos];
        if (w_en) begin
            m_hash[w_addr] <= w_hash;
            m_key[w_addr]  <= w_key;
            m_data[w_addr] <= w_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rv <= r_valid[r_pos];
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        w_en   <= 1'b0;
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_count <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd   <= i_req.command;
                        r_h     <= in_h;
                        r_k     <= KEY_BITS'(i_req.lookup_key);
                        r_v     <= VALUE_BITS'(i_req.in_value);
                        r_pos   <= in_h[AW-1:0];
                        r_len   <= '0;
                        r_found <= 1'b0;
                        r_outv  <= '0;
                        r_state <= (i_req.command == CMD_SPARE) ? S_DONE : S_LREAD;
                    end
                end
                S_LREAD: r_state <= S_LDEC;
                S_LDEC: begin
                    // Search step: stop on empty, match, a richer resident or a full wrap.
                    if (!r_rv || {1'b0, probe_off} < r_len || r_len == (AW+1)'(CAPACITY)) begin
                        r_state <= S_DISP;
                    end else if (r_rh == r_h && r_rk == r_k) begin
                        r_found <= 1'b1;
                        r_where <= r_pos;
                        r_outv  <= r_rd;
                        r_state <= S_DISP;
                    end else begin
                        r_len   <= r_len + 1'b1;
                        r_pos   <= r_pos + ONE;
                        r_state <= S_LREAD;
                    end
                end
                S_DISP: begin
                    // The load verdict is taken before the count can move.
                    r_full  <= load_over;
                    r_state <= S_DONE;
                    if (r_cmd == CMD_PUT && !load_over) begin
                        if (r_found) begin
                            w_en   <= 1'b1;
                            w_addr <= r_where;
                            w_hash <= r_h;
                            w_key  <= r_k;
                            w_data <= r_v;
                        end else begin
                            r_pos   <= r_h[AW-1:0];
                            r_len   <= '0;
                            r_state <= S_IREAD;
                        end
                    end else if (r_cmd == CMD_DEL && r_found) begin
                        r_pos   <= r_where + ONE;
                        r_state <= S_RREAD;
                    end
                end
                S_IREAD: r_state <= S_IDEC;
                S_IDEC: begin
                    // Insert step: fill an empty slot or swap with a richer resident.
                    if (!r_rv) begin
                        w_en    <= 1'b1;
                        w_addr  <= r_pos;
                        w_hash  <= r_h;
                        w_key   <= r_k;
                        w_data  <= r_v;
                        r_valid[r_pos] <= 1'b1;
                        r_count <= r_count + 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        if ({1'b0, probe_off} < r_len) begin
                            w_en   <= 1'b1;
                            w_addr <= r_pos;
                            w_hash <= r_h;
                            w_key  <= r_k;
                            w_data <= r_v;
                            r_h    <= r_rh;
                            r_k    <= r_rk;
                            r_v    <= r_rd;
                            r_len  <= {1'b0, probe_off} + 1'b1;
                        end else begin
                            r_len  <= r_len + 1'b1;
                        end
                        r_pos   <= r_pos + ONE;
                        r_state <= S_IREAD;
                    end
                end
                S_RREAD: r_state <= S_RDEC;
                S_RDEC: begin
                    // Backward shift: move the next resident down one slot, or stop and free the slot behind.
                    if (!r_rv || probe_off == '0 || r_pos == r_where) begin
                        r_valid[r_pos - ONE] <= 1'b0;
                        r_count <= r_count - 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        w_en    <= 1'b1;
                        w_addr  <= r_pos - ONE;
                        w_hash  <= r_rh;
                        w_key   <= r_rk;
                        w_data  <= r_rd;
                        r_pos   <= r_pos + ONE;
                        r_state <= S_RREAD;
                    end
                end
                S_DONE: begin
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result, valid while o_done is high.
    always_comb begin
        o_rsp = '0;
        o_rsp.entry_count = 9'(r_count);
        if (r_cmd != CMD_SPARE) begin
            o_rsp.was_present = r_found;
            if (r_cmd == CMD_PUT) begin
                o_rsp.status = r_full ? ST_FULL : ST_OK;
            end else if (!r_found) begin
                o_rsp.status = ST_NOTFOUND;
            end else begin
                o_rsp.out_value = 32'(r_outv);
                if (r_cmd == CMD_GET) begin
                    o_rsp.slot_index = 8'(r_where);
                end
            end
        end
    end
endmodule
`default_nettype wire
